// ----- design/point_cloud_region_mask_filter_defines.svh -----
// Assertion helpers shared by the filter RTL.
`ifndef POINT_CLOUD_REGION_MASK_FILTER_DEFINES_SVH
`define POINT_CLOUD_REGION_MASK_FILTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PCRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pcrm_pkg.sv -----
`default_nettype none

package pcrm_pkg;

  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  typedef enum logic [2:0] {
    REG_ENABLES = 3'd0,
    REG_DESK    = 3'd1,
    REG_BOX_MIN = 3'd2,
    REG_BOX_MAX = 3'd3,
    REG_CENTER  = 3'd4,
    REG_RADIUS  = 3'd5
  } reg_idx_e;

  // x in the low bits, z in the high bits
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vec3_t;

  typedef struct packed {
    logic [2:0]         enables;
    logic signed [15:0] desk_cut;
    vec3_t              box_min;
    vec3_t              box_max;
    vec3_t              center;
    logic [14:0]        radius;
  } cfg_t;

  typedef struct packed {
    logic [14:0] radius;
    vec3_t       center;
  } mask_entry_t;

  typedef struct packed {
    logic in_rad;   // squared distance <= radius squared
    logic rad_nz;   // radius is nonzero
  } lane_res_t;

  localparam logic [2:0]  ENABLES_RST = 3'd1;
  localparam logic [15:0] DESK_RST    = 16'd10;
  localparam logic [14:0] RADIUS_RST  = 15'd250;

  localparam int unsigned EN_DESK   = 0;
  localparam int unsigned EN_BOX    = 1;
  localparam int unsigned EN_SPHERE = 2;

endpackage

`default_nettype wire

// ----- design/pcrm_regs.sv -----
`default_nettype none

module pcrm_regs
  import pcrm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[5:3];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ENABLES: cfg_d.enables  = pwdata[2:0];
        REG_DESK:    cfg_d.desk_cut = pwdata[15:0];
        REG_BOX_MIN: cfg_d.box_min  = pwdata[47:0];
        REG_BOX_MAX: cfg_d.box_max  = pwdata[47:0];
        REG_CENTER:  cfg_d.center   = pwdata[47:0];
        REG_RADIUS:  cfg_d.radius   = pwdata[14:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enables  <= ENABLES_RST;
      cfg_q.desk_cut <= DESK_RST;
      cfg_q.box_min  <= '0;
      cfg_q.box_max  <= '0;
      cfg_q.center   <= '0;
      cfg_q.radius   <= RADIUS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLES: prdata = {61'd0, cfg_q.enables};
      REG_DESK:    prdata = {48'd0, cfg_q.desk_cut};
      REG_BOX_MIN: prdata = {16'd0, cfg_q.box_min};
      REG_BOX_MAX: prdata = {16'd0, cfg_q.box_max};
      REG_CENTER:  prdata = {16'd0, cfg_q.center};
      REG_RADIUS:  prdata = {49'd0, cfg_q.radius};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/pcrm_mask_table.sv -----
`default_nettype none

module pcrm_mask_table
  import pcrm_pkg::*;
#(
  parameter int unsigned MASK_SLOTS = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [2:0]                   slot_i,
  input  mask_entry_t                       entry_i,
  output mask_entry_t [MASK_SLOTS-1:0]      entries_o
);

  mask_entry_t [MASK_SLOTS-1:0] tbl_q;

  // slots beyond the table never match and the write is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_q <= '0;
    end else begin
      for (int i = 0; i < MASK_SLOTS; i++) begin
        if (wr_en_i && ({3'd0, slot_i} == 6'(i))) begin
          tbl_q[i] <= entry_i;
        end
      end
    end
  end

  assign entries_o = tbl_q;

endmodule

`default_nettype wire

// ----- design/pcrm_dist_lane.sv -----
`default_nettype none

module pcrm_dist_lane
  import pcrm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  vec3_t            point_i,
  input  vec3_t            center_i,
  input  wire logic [14:0] radius_i,
  output lane_res_t        res_o
);

  logic [31:0] sq_q [3];
  logic [29:0] r2_q;
  logic        nz_q;
  logic signed [15:0] pc [3];
  logic signed [15:0] cc [3];
  logic [15:0] mag [3];
  logic [33:0] sum;

  assign pc[0] = point_i.x;
  assign pc[1] = point_i.y;
  assign pc[2] = point_i.z;
  assign cc[0] = center_i.x;
  assign cc[1] = center_i.y;
  assign cc[2] = center_i.z;

  always_comb begin
    logic signed [16:0] d;
    for (int k = 0; k < 3; k++) begin
      d = {pc[k][15], pc[k]} - {cc[k][15], cc[k]};
      mag[k] = d[16] ? 16'(-d) : d[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= mag[k] * mag[k];
      end
      r2_q <= radius_i * radius_i;
      nz_q <= |radius_i;
    end
  end

  assign sum = {2'd0, sq_q[0]} + {2'd0, sq_q[1]} + {2'd0, sq_q[2]};
  assign res_o.in_rad = sum <= {4'd0, r2_q};
  assign res_o.rad_nz = nz_q;

endmodule

`default_nettype wire

// ----- design/point_cloud_region_mask_filter.sv -----
`default_nettype none

// Region point filter. Takes one item per cycle on the input channel while
// in_stall_o is low and, for a surviving point, presents it on the output
// channel after the input register, squared-distance register and output
// register; the depth is set by the distance lanes, which register the squared
// per-axis differences before the sum and radius compare. Mode 1 items write a mask
// slot as they leave the input register and give no output; points behind them
// see the new entry. The mask table is cleared by reset in the same cycle, with
// no clearing pass. Configuration registers sit at byte address 8*index on the
// APB port and must only be written while no item is in flight.
module point_cloud_region_mask_filter
  import pcrm_pkg::*;
#(
  parameter int unsigned MASK_SLOTS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic               point_finite_i,
  input  wire logic signed [15:0] coord_x_i,
  input  wire logic signed [15:0] coord_y_i,
  input  wire logic signed [15:0] coord_z_i,
  input  wire logic [2:0]         slot_i,
  input  wire logic [14:0]        mask_radius_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      kept_x_o,
  output logic signed [15:0]      kept_y_o,
  output logic signed [15:0]      kept_z_o
);

`include "point_cloud_region_mask_filter_defines.svh"

  cfg_t cfg;
  mask_entry_t [MASK_SLOTS-1:0] entries;

  logic        v0_q, v1_q, v2_q;
  logic        mode_q, fin_q;
  vec3_t       pt0_q, pt1_q, pt2_q;
  logic [2:0]  slot_q;
  logic [14:0] rad_q;
  logic        adv0, adv1, adv2;
  logic        in_box, desk_ok, box_ok, pre_pass, keep;
  logic        tbl_wr;
  lane_res_t   region_res;
  lane_res_t   mask_res [MASK_SLOTS];
  logic [MASK_SLOTS-1:0] hit;

  pcrm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // each stage moves on when the one after it is empty or moving
  assign adv2       = !v2_q || !out_stall_i;
  assign adv1       = !v1_q || adv2;
  assign adv0       = !v0_q || adv1;
  assign in_stall_o = !adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= in_valid_i;
      if (adv1) v1_q <= v0_q && !mode_q && pre_pass;
      if (adv2) v2_q <= v1_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      mode_q   <= mode_i;
      fin_q    <= point_finite_i;
      pt0_q.x  <= coord_x_i;
      pt0_q.y  <= coord_y_i;
      pt0_q.z  <= coord_z_i;
      slot_q   <= slot_i;
      rad_q    <= mask_radius_i;
    end
    if (adv1) pt1_q <= pt0_q;
    if (adv2) pt2_q <= pt1_q;
  end

  // stage 0: flag, desk and box checks
  assign in_box = (pt0_q.x >= cfg.box_min.x) && (pt0_q.x <= cfg.box_max.x) &&
                  (pt0_q.y >= cfg.box_min.y) && (pt0_q.y <= cfg.box_max.y) &&
                  (pt0_q.z >= cfg.box_min.z) && (pt0_q.z <= cfg.box_max.z);
  assign desk_ok  = !cfg.enables[EN_DESK] || (pt0_q.z > cfg.desk_cut);
  assign box_ok   = !cfg.enables[EN_BOX] || in_box;
  assign pre_pass = fin_q && desk_ok && box_ok;

  assign tbl_wr = v0_q && mode_q && adv1;

  pcrm_mask_table #(
    .MASK_SLOTS (MASK_SLOTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_wr),
    .slot_i    (slot_q),
    .entry_i   ({rad_q, pt0_q}),
    .entries_o (entries)
  );

  pcrm_dist_lane u_region (
    .clk_i    (clk_i),
    .en_i     (adv1),
    .point_i  (pt0_q),
    .center_i (cfg.center),
    .radius_i (cfg.radius),
    .res_o    (region_res)
  );

  for (genvar i = 0; i < MASK_SLOTS; i++) begin : g_mask
    pcrm_dist_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (adv1),
      .point_i  (pt0_q),
      .center_i (entries[i].center),
      .radius_i (entries[i].radius),
      .res_o    (mask_res[i])
    );
    // a freed slot never masks, not even its own centre
    assign hit[i] = mask_res[i].in_rad && mask_res[i].rad_nz;
  end

  assign keep = (!cfg.enables[EN_SPHERE] || region_res.in_rad) && !(|hit);

  assign out_valid_o = v2_q;
  assign kept_x_o    = pt2_q.x;
  assign kept_y_o    = pt2_q.y;
  assign kept_z_o    = pt2_q.z;

  `PCRM_ASSERT_NOW(a_stall_from_output, in_stall_o, out_valid_o && out_stall_i,
                   "input stalled while output is free")
  `PCRM_ASSERT_NEXT(a_mask_write_no_point, v0_q && mode_q && adv1, !v1_q,
                    "mask write item passed on as a point")
  `PCRM_ASSERT_NOW(a_desk_holds, out_valid_o && cfg.enables[EN_DESK],
                   kept_z_o > cfg.desk_cut, "kept point at or below desk cut")
  `PCRM_ASSERT_NOW(a_box_holds, out_valid_o && cfg.enables[EN_BOX],
                   kept_x_o >= cfg.box_min.x && kept_x_o <= cfg.box_max.x &&
                   kept_z_o >= cfg.box_min.z && kept_z_o <= cfg.box_max.z,
                   "kept point outside box")

endmodule

`default_nettype wire

// ----- verif/pcrm_tb_pkg.sv -----
`timescale 1ns / 100ps

package pcrm_tb_pkg;

  typedef enum logic {
    ITEM_POINT = 1'b0,
    ITEM_MASK  = 1'b1
  } item_mode_e;

endpackage

// ----- verif/pcrm_filter_checker.sv -----
`timescale 1ns / 100ps

module pcrm_filter_checker
  import pcrm_pkg::*;
  import pcrm_tb_pkg::*;
#(
  parameter int unsigned MASK_SLOTS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  input  logic                     in_valid_i,
  input  logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic                     point_finite_i,
  input  logic signed [15:0]       coord_x_i,
  input  logic signed [15:0]       coord_y_i,
  input  logic signed [15:0]       coord_z_i,
  input  logic [2:0]               slot_i,
  input  logic [14:0]              mask_radius_i,
  input  logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  logic signed [15:0]       kept_x_o,
  input  logic signed [15:0]       kept_y_o,
  input  logic signed [15:0]       kept_z_o,
  output int                       fail_count,
  output int                       pending
);

  cfg_t        cfg;
  mask_entry_t masks [MASK_SLOTS];
  vec3_t       kept_q [$];

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic queue_kept(vec3_t pt);
    kept_q = {kept_q, pt};
  endtask

  function automatic longint dist_sq(vec3_t a, vec3_t b);
    longint dx, dy, dz;
    dx = longint'($signed(a.x)) - longint'($signed(b.x));
    dy = longint'($signed(a.y)) - longint'($signed(b.y));
    dz = longint'($signed(a.z)) - longint'($signed(b.z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic bit point_survives(vec3_t p);
    longint r;
    if (cfg.enables[EN_DESK] && $signed(p.z) <= $signed(cfg.desk_cut)) return 1'b0;
    if (cfg.enables[EN_BOX]) begin
      if ($signed(p.x) < $signed(cfg.box_min.x) || $signed(p.x) > $signed(cfg.box_max.x) ||
          $signed(p.y) < $signed(cfg.box_min.y) || $signed(p.y) > $signed(cfg.box_max.y) ||
          $signed(p.z) < $signed(cfg.box_min.z) || $signed(p.z) > $signed(cfg.box_max.z))
        return 1'b0;
    end
    if (cfg.enables[EN_SPHERE]) begin
      r = longint'(cfg.radius);
      if (dist_sq(p, cfg.center) > r * r) return 1'b0;
    end
    for (int i = 0; i < MASK_SLOTS; i++) begin
      r = longint'(masks[i].radius);
      // radius zero marks a free slot
      if (r != 0 && dist_sq(p, masks[i].center) <= r * r) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic apply_write(logic [PADDR_W-4:0] idx, logic [PDATA_W-1:0] wdata);
    case (reg_idx_e'(idx))
      REG_ENABLES: cfg.enables  = wdata[2:0];
      REG_DESK:    cfg.desk_cut = wdata[15:0];
      REG_BOX_MIN: cfg.box_min  = wdata[47:0];
      REG_BOX_MAX: cfg.box_max  = wdata[47:0];
      REG_CENTER:  cfg.center   = wdata[47:0];
      REG_RADIUS:  cfg.radius   = wdata[14:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vec3_t p, got, want;
    if (!rst_ni) begin
      cfg.enables  = ENABLES_RST;
      cfg.desk_cut = DESK_RST;
      cfg.box_min  = '0;
      cfg.box_max  = '0;
      cfg.center   = '0;
      cfg.radius   = RADIUS_RST;
      for (int i = 0; i < MASK_SLOTS; i++) masks[i] = '0;
      kept_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) apply_write(paddr[PADDR_W-1:3], pwdata);

      if (in_valid_i && !in_stall_o) begin
        p = vec3_t'({coord_z_i, coord_y_i, coord_x_i});
        if (mode_i == ITEM_MASK) begin
          if (slot_i < MASK_SLOTS) masks[slot_i] = mask_entry_t'({mask_radius_i, p});
        end else if (point_finite_i && point_survives(p)) begin
          queue_kept(p);
        end
      end

      if (out_valid_o && !out_stall_i) begin
        got = vec3_t'({kept_z_o, kept_y_o, kept_x_o});
        if (kept_q.size() == 0) begin
          report_mismatch($sformatf("unexpected point (%0d,%0d,%0d)",
                                    $signed(got.x), $signed(got.y), $signed(got.z)));
        end else begin
          want = kept_q.pop_front();
          if (got.x !== want.x)
            report_mismatch($sformatf("kept_x %0d, want %0d", $signed(got.x), $signed(want.x)));
          if (got.y !== want.y)
            report_mismatch($sformatf("kept_y %0d, want %0d", $signed(got.y), $signed(want.y)));
          if (got.z !== want.z)
            report_mismatch($sformatf("kept_z %0d, want %0d", $signed(got.z), $signed(want.z)));
        end
      end

      pending <= kept_q.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import pcrm_pkg::*;
  import pcrm_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 75;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr          = '0;
  logic [PDATA_W-1:0] pwdata         = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               mode_i         = 1'b0;
  logic               point_finite_i = 1'b0;
  logic signed [15:0] coord_x_i      = '0;
  logic signed [15:0] coord_y_i      = '0;
  logic signed [15:0] coord_z_i      = '0;
  logic [2:0]         slot_i         = '0;
  logic [14:0]        mask_radius_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic signed [15:0] kept_x_o;
  logic signed [15:0] kept_y_o;
  logic signed [15:0] kept_z_o;

  int fail_count;
  int pending;
  int cycles      = 0;
  int burst_left  = 1;
  int stall_style = 0;
  int stall_left  = 0;

  always #5 clk_i = ~clk_i;

  point_cloud_region_mask_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .point_finite_i(point_finite_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .slot_i        (slot_i),
    .mask_radius_i (mask_radius_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kept_x_o      (kept_x_o),
    .kept_y_o      (kept_y_o),
    .kept_z_o      (kept_z_o)
  );

  pcrm_filter_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .point_finite_i(point_finite_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .slot_i        (slot_i),
    .mask_radius_i (mask_radius_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kept_x_o      (kept_x_o),
    .kept_y_o      (kept_y_o),
    .kept_z_o      (kept_z_o),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // receiver: stall style is redrawn whenever its countdown runs out, style 0 never stalls
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL point_cloud_region_mask_filter");
      $finish;
    end
  end

  function automatic vec3_t v3(shortint x, shortint y, shortint z);
    return vec3_t'({z, y, x});
  endfunction

  function automatic shortint rand_coord();
    case ($urandom_range(0, 9))
      0: return shortint'($urandom);
      1: return shortint'($urandom_range(0, 1) ? 32767 : -32768);
      default: return shortint'(int'($urandom_range(0, 800)) - 400);
    endcase
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // holds the item until taken; valid stays high within a burst
  task automatic send_item(item_mode_e m, logic fin, shortint x, shortint y, shortint z,
                           logic [2:0] s = 3'd0, logic [14:0] r = 15'd0);
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    point_finite_i <= fin;
    coord_x_i      <= x;
    coord_y_i      <= y;
    coord_z_i      <= z;
    slot_i         <= s;
    mask_radius_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
    end
  endtask

  // mode 1 items and dropped points leave no trace, so let the pipe empty too
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    shortint     x, y, z, mx, my, mz;
    shortint     bl [3];
    shortint     bh [3];
    logic [14:0] r;

    mx = 0;
    my = 0;
    mz = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: desk cut only, at 10
    send_item(ITEM_POINT, 1'b1, 0, 0, 11);
    send_item(ITEM_POINT, 1'b1, 0, 0, 10);
    send_item(ITEM_POINT, 1'b0, 0, 0, 500);
    send_item(ITEM_MASK, 1'b0, 100, 100, 100, 3'd0, 15'd50);
    send_item(ITEM_POINT, 1'b1, 150, 100, 100);
    send_item(ITEM_POINT, 1'b1, 151, 100, 100);
    send_item(ITEM_POINT, 1'b1, 100, 100, 100);
    send_item(ITEM_MASK, 1'b1, 100, 100, 100, 3'd0, 15'd0);
    send_item(ITEM_POINT, 1'b1, 100, 100, 100);
    send_item(ITEM_MASK, 1'b1, -32768, -32768, -32768, 3'd7, 15'd32767);
    send_item(ITEM_POINT, 1'b1, 32767, 32767, 32767);
    send_item(ITEM_POINT, 1'b1, -32768, -1, 32767);
    send_item(ITEM_POINT, 1'b1, -32768, 32767, -32768);
    send_item(ITEM_MASK, 1'b1, 32767, 32767, 32767, 3'd7, 15'd0);
    wait_idle();

    // all checks on; the box faces touch the keep sphere
    write_reg(REG_ENABLES, 64'd7);
    write_reg(REG_DESK, {48'd0, 16'(-100)});
    write_reg(REG_BOX_MIN, {16'd0, v3(-100, -100, -100)});
    write_reg(REG_BOX_MAX, {16'd0, v3(100, 100, 100)});
    write_reg(REG_CENTER, {16'd0, v3(0, 0, 0)});
    write_reg(REG_RADIUS, 64'd100);
    send_item(ITEM_POINT, 1'b1, 100, 0, 0);
    send_item(ITEM_POINT, 1'b1, 101, 0, 0);
    send_item(ITEM_POINT, 1'b1, 0, -100, 0);
    send_item(ITEM_POINT, 1'b1, 0, 0, -100);
    send_item(ITEM_POINT, 1'b1, 0, 0, -99);
    send_item(ITEM_POINT, 1'b1, 60, 60, 60);
    wait_idle();

    // inverted box in x
    write_reg(REG_ENABLES, 64'd2);
    write_reg(REG_BOX_MIN, {16'd0, v3(10, -100, -100)});
    write_reg(REG_BOX_MAX, {16'd0, v3(-10, 100, 100)});
    send_item(ITEM_POINT, 1'b1, 0, 0, 0);
    send_item(ITEM_POINT, 1'b1, 10, 0, 0);
    wait_idle();

    // extremes, first with every check off
    write_reg(REG_ENABLES, 64'd0);
    write_reg(REG_DESK, {48'd0, 16'(32767)});
    write_reg(REG_BOX_MIN, {16'd0, v3(-32768, -32768, -32768)});
    write_reg(REG_BOX_MAX, {16'd0, v3(32767, 32767, 32767)});
    write_reg(REG_CENTER, {16'd0, v3(32767, 32767, -32768)});
    write_reg(REG_RADIUS, 64'd32767);
    send_item(ITEM_POINT, 1'b1, -32768, -32768, -32768);
    send_item(ITEM_POINT, 1'b1, 32767, 32767, 32767);
    wait_idle();
    write_reg(REG_ENABLES, 64'd7);
    write_reg(REG_DESK, {48'd0, 16'(-32768)});
    write_reg(REG_CENTER, {16'd0, v3(0, 0, 0)});
    send_item(ITEM_POINT, 1'b1, 0, 0, -32768);
    send_item(ITEM_POINT, 1'b1, 32767, 0, 0);
    send_item(ITEM_POINT, 1'b1, 32767, 0, 1);
    send_item(ITEM_POINT, 1'b1, 0, 0, -32767);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int k = 0; k < 3; k++) begin
        if (ph == 0) begin
          bl[k] = rand_coord();
          bh[k] = rand_coord();
        end else begin
          bl[k] = shortint'(int'($urandom_range(0, 800)) - 400);
          bh[k] = shortint'(int'(bl[k]) + int'($urandom_range(0, 640)) - 40);
        end
      end
      write_reg(REG_ENABLES, 64'($urandom_range(0, 7)));
      write_reg(REG_DESK, {48'd0, 16'(($urandom_range(0, 4) == 0) ? rand_coord()
                                       : int'($urandom_range(0, 600)) - 300)});
      write_reg(REG_BOX_MIN, {16'd0, v3(bl[0], bl[1], bl[2])});
      write_reg(REG_BOX_MAX, {16'd0, v3(bh[0], bh[1], bh[2])});
      write_reg(REG_CENTER, {16'd0, v3(rand_coord(), rand_coord(), rand_coord())});
      write_reg(REG_RADIUS, 64'((ph == 0) ? $urandom_range(0, 32767)
                                : ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(50, 600)));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          mx = rand_coord();
          my = rand_coord();
          mz = rand_coord();
          case ($urandom_range(0, 15))
            0:       r = 15'd0;
            1:       r = 15'($urandom_range(0, 32767));
            default: r = 15'($urandom_range(1, 150));
          endcase
          send_item(ITEM_MASK, 1'($urandom_range(0, 1)), mx, my, mz,
                    3'($urandom_range(0, 7)), r);
        end else begin
          if ($urandom_range(0, 4) == 0) begin
            // aim near the latest mask sphere
            x = mx + shortint'(int'($urandom_range(0, 200)) - 100);
            y = my + shortint'(int'($urandom_range(0, 200)) - 100);
            z = mz + shortint'(int'($urandom_range(0, 200)) - 100);
          end else begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
          end
          send_item(ITEM_POINT, 1'($urandom_range(0, 9) != 0), x, y, z,
                    3'($urandom_range(0, 7)), 15'($urandom_range(0, 32767)));
        end
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("PASS point_cloud_region_mask_filter");
    end else begin
      $display("FAIL point_cloud_region_mask_filter");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/pcrm_pkg.sv
design/pcrm_regs.sv
design/pcrm_mask_table.sv
design/pcrm_dist_lane.sv
design/point_cloud_region_mask_filter.sv
verif/pcrm_tb_pkg.sv
verif/pcrm_filter_checker.sv
verif/tb.sv
